// File: rtl/perlin_noise_2d_sampler_unit_defines.svh
// Assertion macros shared by the checker of the noise sampler.
// Holds no logic of its own and depends on nothing else.
`ifndef PERLIN_NOISE_2D_SAMPLER_UNIT_DEFINES_SVH
`define PERLIN_NOISE_2D_SAMPLER_UNIT_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define PNS_ASSERT_NOW(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error("noise sampler check failed");

// Consequent must hold in the cycle after the antecedent.
`define PNS_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error("noise sampler check failed");

`endif

// File: rtl/pns_pkg.sv
// Shared types and constants of the gradient noise sampler.
// Used by every RTL module of the block; depends on nothing.
package pns_pkg;

  localparam int PERM_AW    = 8;
  localparam int TABLE_SIZE = 1 << PERM_AW;
  localparam int PERM_W     = 8;
  localparam int GRAD_W     = 3;
  localparam int POS_W      = 32;
  localparam int FRAC_W     = 16;
  localparam int RES_W      = 16;
  localparam int NUM_W      = POS_W + 8;
  localparam int DIV_STAGES = NUM_W;
  localparam int LOC_LAT    = DIV_STAGES + 2;
  localparam int QLOW_W     = PERM_AW + FRAC_W;
  localparam int BLEND_LAT  = 8;
  localparam int OUT_W      = 16;
  localparam int APB_AW     = 3;
  localparam int APB_DW     = 32;
  localparam int FIFO_DEPTH = 2;

  localparam logic [RES_W-1:0] RES_RESET = RES_W'(256);
  localparam logic [16:0]      GRAD_UNIT = 17'd46341;

  localparam logic MODE_LOAD = 1'b0;
  localparam logic MODE_EVAL = 1'b1;

  localparam logic REG_RESOLUTION = 1'b0;

  typedef enum logic [GRAD_W-1:0] {
    G_PP, G_NP, G_PN, G_NN, G_XP, G_XN, G_YP, G_YN
  } grad_e;

  typedef struct packed {
    logic              valid;
    logic              mode;
    logic [PERM_AW-1:0] idx;
    logic [PERM_W-1:0]  val;
  } beat_t;

endpackage

// File: rtl/pns_locate.sv
// Coordinate scaling: divides both coordinates by the resolution with a
// bit-per-stage restoring divider and floors the result to cell and fraction.
// Depends on pns_pkg.
module pns_locate (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              en_i,
  input  logic [pns_pkg::RES_W-1:0]         res_i,
  input  pns_pkg::beat_t                    ctl_i,
  input  logic [pns_pkg::POS_W-1:0]         x_pos_i,
  input  logic [pns_pkg::POS_W-1:0]         y_pos_i,
  output pns_pkg::beat_t                    ctl_o,
  output logic [pns_pkg::PERM_AW-1:0]       cell_o [2],
  output logic [pns_pkg::FRAC_W-1:0]        frac_o [2]
);
  import pns_pkg::*;

  logic [RES_W-1:0]  div;
  logic [POS_W-1:0]  pos [2];
  beat_t             ctl_q [LOC_LAT];
  logic              sign_q [2][DIV_STAGES+1];
  logic [NUM_W-1:0]  dq_q [2][DIV_STAGES+1];
  logic [NUM_W-1:0]  dq_d [2][DIV_STAGES+1];
  logic [RES_W-1:0]  rem_q [2][DIV_STAGES+1];
  logic [RES_W-1:0]  rem_d [2][DIV_STAGES+1];
  logic [QLOW_W-1:0] qlow_q [2];
  logic [QLOW_W-1:0] qlow_d [2];

  always_comb begin
    logic [RES_W:0]    trial;
    logic              take;
    logic [QLOW_W-1:0] quo;
    logic              rnz;
    div    = (res_i == '0) ? RES_W'(1) : res_i;
    pos[0] = x_pos_i;
    pos[1] = y_pos_i;
    for (int l = 0; l < 2; l++) begin
      dq_d[l][0]  = {(pos[l][POS_W-1] ? POS_W'(-pos[l]) : pos[l]), {(NUM_W-POS_W){1'b0}}};
      rem_d[l][0] = '0;
      for (int k = 1; k <= DIV_STAGES; k++) begin
        trial = {rem_q[l][k-1], dq_q[l][k-1][NUM_W-1]};
        take  = (trial >= {1'b0, div});
        if (take) begin
          rem_d[l][k] = RES_W'(trial - {1'b0, div});
        end else begin
          rem_d[l][k] = trial[RES_W-1:0];
        end
        dq_d[l][k] = {dq_q[l][k-1][NUM_W-2:0], take};
      end
      // A negative point takes the ceiling of the magnitude, negated; a
      // positive point keeps the truncated quotient, which is its floor.
      quo = dq_q[l][DIV_STAGES][QLOW_W-1:0];
      rnz = |rem_q[l][DIV_STAGES];
      if (sign_q[l][DIV_STAGES]) begin
        qlow_d[l] = ~quo + QLOW_W'(!rnz);
      end else begin
        qlow_d[l] = quo;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int l = 0; l < 2; l++) begin
        sign_q[l][0] <= pos[l][POS_W-1];
        for (int k = 1; k <= DIV_STAGES; k++) begin
          sign_q[l][k] <= sign_q[l][k-1];
        end
      end
      dq_q   <= dq_d;
      rem_q  <= rem_d;
      qlow_q <= qlow_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < LOC_LAT; k++) begin
        ctl_q[k] <= '0;
      end
    end else if (en_i) begin
      ctl_q[0] <= ctl_i;
      for (int k = 1; k < LOC_LAT; k++) begin
        ctl_q[k] <= ctl_q[k-1];
      end
    end
  end

  assign ctl_o = ctl_q[LOC_LAT-1];
  always_comb begin
    for (int l = 0; l < 2; l++) begin
      cell_o[l] = qlow_q[l][QLOW_W-1:FRAC_W];
      frac_o[l] = qlow_q[l][FRAC_W-1:0];
    end
  end

endmodule

// File: rtl/pns_lookup.sv
// Permutation lookups: three copies of the table, written by load beats as
// they pass, give the gradient index of each corner. Depends on pns_pkg.
module pns_lookup (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         en_i,
  input  pns_pkg::beat_t               ctl_i,
  input  logic [pns_pkg::PERM_AW-1:0]  cell_i [2],
  input  logic [pns_pkg::FRAC_W-1:0]   frac_i [2],
  output pns_pkg::beat_t               ctl_o,
  output logic [pns_pkg::FRAC_W-1:0]   fx_o,
  output logic [pns_pkg::FRAC_W-1:0]   fy_o,
  output logic [pns_pkg::GRAD_W-1:0]   grad_o [4]
);
  import pns_pkg::*;

  logic [PERM_W-1:0]  mem_a  [TABLE_SIZE];
  logic [PERM_W-1:0]  mem_b0 [TABLE_SIZE];
  logic [PERM_W-1:0]  mem_b1 [TABLE_SIZE];
  beat_t              ctl_a_q, ctl_b_q;
  logic [PERM_AW-1:0] ci_a_q, pj0_q, pj1_q, cj1, ci1;
  logic [PERM_AW-1:0] addr [4];
  logic [FRAC_W-1:0]  fx_a_q, fy_a_q, fx_b_q, fy_b_q;
  logic [GRAD_W-1:0]  grad_q [4];
  logic               wr_a, wr_b;

  always_comb begin
    cj1     = cell_i[1] + PERM_AW'(1);
    ci1     = ci_a_q + PERM_AW'(1);
    addr[0] = ci_a_q + pj0_q;
    addr[1] = ci1 + pj0_q;
    addr[2] = ci_a_q + pj1_q;
    addr[3] = ci1 + pj1_q;
    wr_a    = en_i && ctl_i.valid && (ctl_i.mode == MODE_LOAD);
    wr_b    = en_i && ctl_a_q.valid && (ctl_a_q.mode == MODE_LOAD);
  end

  always_ff @(posedge clk_i) begin
    if (wr_a) begin
      mem_a[ctl_i.idx] <= ctl_i.val;
    end
    if (en_i) begin
      pj0_q  <= mem_a[cell_i[1]];
      pj1_q  <= mem_a[cj1];
      ci_a_q <= cell_i[0];
      fx_a_q <= frac_i[0];
      fy_a_q <= frac_i[1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_b) begin
      mem_b0[ctl_a_q.idx] <= ctl_a_q.val;
    end
    if (en_i) begin
      grad_q[0] <= mem_b0[addr[0]][GRAD_W-1:0];
      grad_q[1] <= mem_b0[addr[1]][GRAD_W-1:0];
      fx_b_q    <= fx_a_q;
      fy_b_q    <= fy_a_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_b) begin
      mem_b1[ctl_a_q.idx] <= ctl_a_q.val;
    end
    if (en_i) begin
      grad_q[2] <= mem_b1[addr[2]][GRAD_W-1:0];
      grad_q[3] <= mem_b1[addr[3]][GRAD_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_a_q <= '0;
      ctl_b_q <= '0;
    end else if (en_i) begin
      ctl_a_q <= ctl_i;
      ctl_b_q <= ctl_a_q;
    end
  end

  assign ctl_o  = ctl_b_q;
  assign fx_o   = fx_b_q;
  assign fy_o   = fy_b_q;
  assign grad_o = grad_q;

endmodule

// File: rtl/pns_blend.sv
// Dot products, cubic fade and the two-level blend with final saturation,
// cut into eight register stages. Depends on pns_pkg.
module pns_blend (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               en_i,
  input  pns_pkg::beat_t                     ctl_i,
  input  logic [pns_pkg::FRAC_W-1:0]         fx_i,
  input  logic [pns_pkg::FRAC_W-1:0]         fy_i,
  input  logic [pns_pkg::GRAD_W-1:0]         grad_i [4],
  output pns_pkg::beat_t                     ctl_o,
  output logic signed [pns_pkg::OUT_W-1:0]   noise_o
);
  import pns_pkg::*;

  localparam int D_W    = FRAC_W + 2;
  localparam int E_W    = FRAC_W + 3;
  localparam int DOT_W  = 36;
  localparam int W_W    = FRAC_W + 2;
  localparam int P_W    = 2 * FRAC_W + W_W;
  localparam int FADE_W = FRAC_W + 1;
  localparam int DT_W   = DOT_W + 1;
  localparam int LRP_W  = DOT_W + 1;
  localparam int M1_W   = FADE_W + 1 + DT_W;
  localparam int DL_W   = LRP_W + 1;
  localparam int M3_W   = FADE_W + 1 + DL_W;
  localparam int SUM_W  = M3_W + 2;
  localparam logic signed [SUM_W-1:0] SAT_HI = SUM_W'((1 << (OUT_W - 1)) - 1);
  localparam logic signed [SUM_W-1:0] SAT_LO = -SAT_HI - SUM_W'(1);

  beat_t ctl_q [BLEND_LAT];

  logic signed [D_W-1:0]    dxs [2], dys [2];
  logic signed [E_W-1:0]    e_d [4], e_q [4];
  logic                     big_d [4], big_q [4];
  logic [2*FRAC_W-1:0]      t2_q [2];
  logic [W_W-1:0]           w_q [2];
  logic [FRAC_W-1:0]        fin [2];
  logic signed [DOT_W-1:0]  dot_d [4], dot_q [4];
  logic [P_W-1:0]           p_q [2];
  logic [P_W:0]             p_rnd [2];
  logic [FADE_W-1:0]        fade_d [2], cx_q, cy3_q, cy4_q, cy5_q, cy6_q;
  logic signed [DT_W-1:0]   dt_q [2];
  logic signed [DOT_W-1:0]  s3_q, u3_q, s4_q, u4_q;
  logic signed [M1_W-1:0]   m_q [2];
  logic signed [LRP_W-1:0]  l_d [2], l_q [2], l1_6_q, l1_7_q;
  logic signed [DL_W-1:0]   dl_q;
  logic signed [M3_W-1:0]   m3_q;
  logic signed [SUM_W-1:0]  sum, shd;
  logic signed [OUT_W-1:0]  noise_d, noise_q;

  always_comb begin
    logic signed [D_W-1:0]   dx, dy;
    logic signed [M1_W-1:0]  rnd;
    logic signed [DOT_W-1:0] prod;
    fin[0] = fx_i;
    fin[1] = fy_i;
    dxs[0] = $signed({2'b00, fx_i});
    dxs[1] = $signed({2'b00, fx_i}) - $signed({2'b01, {FRAC_W{1'b0}}});
    dys[0] = $signed({2'b00, fy_i});
    dys[1] = $signed({2'b00, fy_i}) - $signed({2'b01, {FRAC_W{1'b0}}});
    for (int c = 0; c < 4; c++) begin
      dx       = dxs[c % 2];
      dy       = dys[c / 2];
      e_d[c]   = '0;
      big_d[c] = 1'b0;
      // Diagonal gradients share the 1/sqrt(2) factor, applied next stage.
      case (grad_e'(grad_i[c]))
        G_PP: e_d[c] = E_W'(dx) + E_W'(dy);
        G_NP: e_d[c] = E_W'(dy) - E_W'(dx);
        G_PN: e_d[c] = E_W'(dx) - E_W'(dy);
        G_NN: e_d[c] = -E_W'(dx) - E_W'(dy);
        G_XP: begin e_d[c] = E_W'(dx);  big_d[c] = 1'b1; end
        G_XN: begin e_d[c] = -E_W'(dx); big_d[c] = 1'b1; end
        G_YP: begin e_d[c] = E_W'(dy);  big_d[c] = 1'b1; end
        G_YN: begin e_d[c] = -E_W'(dy); big_d[c] = 1'b1; end
      endcase
      prod = e_q[c] * $signed({1'b0, GRAD_UNIT});
      if (big_q[c]) begin
        dot_d[c] = DOT_W'(e_q[c]) <<< FRAC_W;
      end else begin
        dot_d[c] = prod;
      end
    end
    for (int i = 0; i < 2; i++) begin
      p_rnd[i]  = {1'b0, p_q[i]} + ((P_W+1)'(1) << (2*FRAC_W - 1));
      fade_d[i] = p_rnd[i][2*FRAC_W +: FADE_W];
      rnd       = m_q[i] + (M1_W'(1) <<< (FRAC_W - 1));
      l_d[i]    = LRP_W'(i == 0 ? s4_q : u4_q) + LRP_W'(rnd >>> FRAC_W);
    end
    sum = (SUM_W'(l1_7_q) <<< FRAC_W) + SUM_W'(m3_q) + (SUM_W'(1) <<< (2*FRAC_W));
    shd = sum >>> (2*FRAC_W + 1);
    if (shd > SAT_HI) begin
      noise_d = SAT_HI[OUT_W-1:0];
    end else if (shd < SAT_LO) begin
      noise_d = SAT_LO[OUT_W-1:0];
    end else begin
      noise_d = shd[OUT_W-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      // Stage 1: corner sums and fade operands.
      e_q   <= e_d;
      big_q <= big_d;
      for (int i = 0; i < 2; i++) begin
        t2_q[i] <= fin[i] * fin[i];
        w_q[i]  <= W_W'(3 << FRAC_W) - W_W'({fin[i], 1'b0});
      end
      // Stage 2: dot products and fade numerators.
      dot_q <= dot_d;
      for (int i = 0; i < 2; i++) begin
        p_q[i] <= t2_q[i] * w_q[i];
      end
      // Stage 3: fade weights and row differences.
      cx_q    <= fade_d[0];
      cy3_q   <= fade_d[1];
      dt_q[0] <= DT_W'(dot_q[1]) - DT_W'(dot_q[0]);
      dt_q[1] <= DT_W'(dot_q[3]) - DT_W'(dot_q[2]);
      s3_q    <= dot_q[0];
      u3_q    <= dot_q[2];
      // Stage 4: row products.
      for (int i = 0; i < 2; i++) begin
        m_q[i] <= $signed({1'b0, cx_q}) * dt_q[i];
      end
      s4_q  <= s3_q;
      u4_q  <= u3_q;
      cy4_q <= cy3_q;
      // Stage 5: row blends.
      l_q   <= l_d;
      cy5_q <= cy4_q;
      // Stage 6: column difference.
      dl_q   <= DL_W'(l_q[1]) - DL_W'(l_q[0]);
      l1_6_q <= l_q[0];
      cy6_q  <= cy5_q;
      // Stage 7: column product.
      m3_q   <= $signed({1'b0, cy6_q}) * dl_q;
      l1_7_q <= l1_6_q;
      // Stage 8: rounding and saturation.
      noise_q <= noise_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < BLEND_LAT; k++) begin
        ctl_q[k] <= '0;
      end
    end else if (en_i) begin
      ctl_q[0] <= ctl_i;
      for (int k = 1; k < BLEND_LAT; k++) begin
        ctl_q[k] <= ctl_q[k-1];
      end
    end
  end

  assign ctl_o   = ctl_q[BLEND_LAT-1];
  assign noise_o = noise_q;

endmodule

// File: rtl/perlin_noise_2d_sampler_unit.sv
// Top level of the two-dimensional gradient noise sampler.
// Instantiates pns_locate, pns_lookup and pns_blend; depends on pns_pkg.
//
// Usage. The input channel carries one beat per item. A beat with mode 0
// writes entry_value into slot entry_index of the permutation table and
// produces no result. A beat with mode 1 evaluates noise at (x_pos, y_pos),
// both signed Q16.16, and produces one noise_value beat in signed Q1.15.
// The table must be filled before it is read. The resolution register
// (Q8.8, zero behaves as the smallest divisor) is written over the APB
// port and reads back its value. The user must write it only while the block
// is idle; the block itself does not enforce this. Throughput is one beat
// per cycle while the pipeline is not held. Accepted beats pass through the
// coordinate divider, whose restoring array settles one quotient bit per
// stage over 40 bits, then the two table lookups, the blend arithmetic and
// the output buffer. Results leave through a two-entry buffer, so a beat is
// still taken while one finished result waits. When the receiver stalls
// further, the whole pipeline holds in place and in_ready_o falls; nothing
// is dropped. Reset clears all valid bits and the buffer and sets the
// resolution to 1.0; the table contents are unknown until written.
module perlin_noise_2d_sampler_unit (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic                              mode_i,
  input  logic [7:0]                        entry_index_i,
  input  logic [7:0]                        entry_value_i,
  input  logic signed [31:0]                x_pos_i,
  input  logic signed [31:0]                y_pos_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic signed [15:0]                noise_value_o,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [pns_pkg::APB_AW-1:0]        paddr,
  input  logic [pns_pkg::APB_DW-1:0]        pwdata,
  output logic [pns_pkg::APB_DW-1:0]        prdata,
  output logic                              pready
);
  import pns_pkg::*;

  logic               en;
  beat_t              in_ctl, loc_ctl, lut_ctl, bl_ctl;
  logic [PERM_AW-1:0] lat_cell [2];
  logic [FRAC_W-1:0]  frac [2];
  logic [FRAC_W-1:0]  fx, fy;
  logic [GRAD_W-1:0]  grad [4];
  logic signed [OUT_W-1:0] bl_noise;
  logic [RES_W-1:0]   res_q;
  logic               cfg_wr;

  logic [OUT_W-1:0]   fifo_q [FIFO_DEPTH];
  logic               wr_ptr_q, rd_ptr_q;
  logic [1:0]         count_q;
  logic               push, pop;

  // The pipeline moves whenever the output buffer can take what the last
  // stage may hand it.
  assign en         = (count_q != 2'(FIFO_DEPTH)) || out_ready_i;
  assign in_ready_o = en;

  assign in_ctl = '{valid: in_valid_i && en, mode: mode_i,
                    idx: entry_index_i, val: entry_value_i};

  pns_locate u_locate (
    .clk_i, .rst_ni, .en_i(en), .res_i(res_q), .ctl_i(in_ctl),
    .x_pos_i(x_pos_i), .y_pos_i(y_pos_i),
    .ctl_o(loc_ctl), .cell_o(lat_cell), .frac_o(frac)
  );

  pns_lookup u_lookup (
    .clk_i, .rst_ni, .en_i(en), .ctl_i(loc_ctl), .cell_i(lat_cell), .frac_i(frac),
    .ctl_o(lut_ctl), .fx_o(fx), .fy_o(fy), .grad_o(grad)
  );

  pns_blend u_blend (
    .clk_i, .rst_ni, .en_i(en), .ctl_i(lut_ctl), .fx_i(fx), .fy_i(fy),
    .grad_i(grad), .ctl_o(bl_ctl), .noise_o(bl_noise)
  );

  // Load beats drain out of the last stage without a result.
  assign push = en && bl_ctl.valid && (bl_ctl.mode == MODE_EVAL);
  assign pop  = out_valid_o && out_ready_i;

  always_ff @(posedge clk_i) begin
    if (push) begin
      fifo_q[wr_ptr_q] <= bl_noise;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= !wr_ptr_q;
      end
      if (pop) begin
        rd_ptr_q <= !rd_ptr_q;
      end
      count_q <= count_q + 2'(push) - 2'(pop);
    end
  end

  assign out_valid_o   = (count_q != '0);
  assign noise_value_o = fifo_q[rd_ptr_q];

  // Configuration port: a single register, always ready.
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == REG_RESOLUTION);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_q <= RES_RESET;
    end else if (cfg_wr) begin
      res_q <= pwdata[RES_W-1:0];
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_RESOLUTION: prdata = APB_DW'(res_q);
      default:        prdata = '0;
    endcase
  end

endmodule

// File: rtl/pns_checker.sv
// Port-level checks on the noise sampler, bound to its top level.
// Depends on pns_pkg and the assertion macros header.
`include "perlin_noise_2d_sampler_unit_defines.svh"

module pns_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        in_ready_o,
  input logic                        out_valid_o,
  input logic                        out_ready_i,
  input logic [15:0]                 noise_value_o,
  input logic                        psel,
  input logic                        penable,
  input logic                        pwrite,
  input logic [pns_pkg::APB_AW-1:0]  paddr,
  input logic [pns_pkg::APB_DW-1:0]  pwdata,
  input logic [pns_pkg::APB_DW-1:0]  prdata
);
  import pns_pkg::*;

  // A waiting result beat keeps its value.
  `PNS_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && !out_ready_i, out_valid_o && $stable(noise_value_o))

  // The input side only stalls when the output buffer is full and blocked.
  `PNS_ASSERT_NOW(a_stall_cause, clk_i, rst_ni, !in_ready_o, out_valid_o && !out_ready_i)

  // A resolution write reads back in the following cycle.
  `PNS_ASSERT_NEXT(a_cfg_readback, clk_i, rst_ni, psel && penable && pwrite && paddr[2] == REG_RESOLUTION, paddr[2] != REG_RESOLUTION || prdata[RES_W-1:0] == $past(pwdata[RES_W-1:0]))

endmodule

bind perlin_noise_2d_sampler_unit pns_checker u_pns_checker (.*);

// File: bench/testbench.sv
// Self-checking bench for perlin_noise_2d_sampler_unit: a directed table, then random beats
// with random idling on both channels. Expected noise comes from a behavioural predictor.
// Depends on pns_pkg and on the RTL of the sampler.
module testbench;
  import pns_pkg::*;

  typedef struct packed {
    logic               mode;
    logic [7:0]         idx;
    logic [7:0]         val;
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic               has_exp;
    logic signed [15:0] exp_noise;
  } noise_req_t;

  localparam int ROWS        = 16;
  localparam int CYCLE_LIMIT = 600000;
  localparam int PIPE_DRAIN  = 70;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic mode_i = 1'b0;
  logic [7:0] entry_index_i = '0;
  logic [7:0] entry_value_i = '0;
  logic signed [31:0] x_pos_i = '0;
  logic signed [31:0] y_pos_i = '0;
  logic out_ready_i = 1'b0;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [APB_AW-1:0] paddr = '0;
  logic [APB_DW-1:0] pwdata = '0;
  logic in_ready_o, out_valid_o, pready;
  logic signed [15:0] noise_value_o;
  logic [APB_DW-1:0] prdata;

  // Predictor state: its own copy of the permutation table and the divisor.
  logic [7:0]  perm_copy [TABLE_SIZE];
  logic [15:0] res_copy;

  logic signed [15:0] noise_due [$];
  int errors = 0;
  int beats_sent = 0;
  int noise_checked = 0;
  int cycles = 0;
  bit hold_done = 1'b0;

  perlin_noise_2d_sampler_unit dut (.*);

  always #1 clk_i = ~clk_i;

  // Watchdog.
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // Appends one expected noise sample to the end of the queue.
  function automatic void queue_noise(input logic signed [15:0] v);
    noise_due.insert(noise_due.size(), v);
  endfunction

  // Splits one coordinate into a lattice cell (already wrapped to 8 bits) and a Q0.16
  // fraction. The division is floored, so negative points keep a non-negative fraction.
  function automatic void split_coord(input logic signed [31:0] pos, input longint divisor,
                                      output logic [7:0] cell_idx, output longint frac);
    longint num, q;
    num = longint'(pos) * 256;
    if (num >= 0) q = num / divisor;
    else q = -((-num + divisor - 1) / divisor);
    frac = q & 64'hFFFF;
    cell_idx = 8'((q >>> 16) & 64'hFF);
  endfunction

  function automatic longint round_q(input longint v, input int n);
    return (v + (longint'(1) << (n - 1))) >>> n;
  endfunction

  function automatic longint smooth_step(input longint t);
    return round_q(3 * t * t * 65536 - 2 * t * t * t, 32);
  endfunction

  // Gradient picked for a corner by two table lookups, dotted with the offset.
  function automatic longint corner_dot(input logic [7:0] ci, input logic [7:0] cj,
                                        input longint dx, input longint dy);
    logic [7:0] slot;
    longint gx, gy;
    slot = ci + perm_copy[cj];
    case (grad_e'(perm_copy[slot][2:0]))
      G_PP: begin gx =  46341; gy =  46341; end
      G_NP: begin gx = -46341; gy =  46341; end
      G_PN: begin gx =  46341; gy = -46341; end
      G_NN: begin gx = -46341; gy = -46341; end
      G_XP: begin gx =  65536; gy =  0; end
      G_XN: begin gx = -65536; gy =  0; end
      G_YP: begin gx =  0;     gy =  65536; end
      default: begin gx = 0;   gy = -65536; end
    endcase
    return gx * dx + gy * dy;
  endfunction

  function automatic logic signed [15:0] noise_at(input logic signed [31:0] x,
                                                  input logic signed [31:0] y);
    longint divisor, fx, fy, s, t, u, v, cx, cy, l1, l2, r;
    logic [7:0] ci, cj;
    divisor = (res_copy == 0) ? 1 : longint'(res_copy);
    split_coord(x, divisor, ci, fx);
    split_coord(y, divisor, cj, fy);
    s = corner_dot(ci, cj, fx, fy);
    t = corner_dot(ci + 8'd1, cj, fx - 65536, fy);
    u = corner_dot(ci, cj + 8'd1, fx, fy - 65536);
    v = corner_dot(ci + 8'd1, cj + 8'd1, fx - 65536, fy - 65536);
    cx = smooth_step(fx);
    cy = smooth_step(fy);
    l1 = round_q(s * 65536 + cx * (t - s), 16);
    l2 = round_q(u * 65536 + cx * (v - u), 16);
    r = round_q(l1 * 65536 + cy * (l2 - l1), 33);
    if (r > 32767) r = 32767;
    if (r < -32768) r = -32768;
    return 16'(r);
  endfunction

  // Offers one beat after a random gap and waits for it to be taken. Valid stays high
  // between back-to-back beats, so it never sees two assignments in one step.
  task automatic send_beat(input noise_req_t b);
    int gap;
    gap = $urandom_range(0, 9);
    if (beats_sent % 200 > 150) gap = 0;
    repeat (gap) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    mode_i <= b.mode;
    entry_index_i <= b.idx;
    entry_value_i <= b.val;
    x_pos_i <= b.x;
    y_pos_i <= b.y;
    do @(posedge clk_i); while (!in_ready_o);
    beats_sent++;
    if (b.mode == MODE_LOAD) begin
      perm_copy[b.idx] = b.val;
    end else begin
      queue_noise(b.has_exp ? b.exp_noise : noise_at(b.x, b.y));
    end
  endtask

  task automatic apb_access(input logic wr, input logic [15:0] data);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= wr;
    paddr <= APB_AW'(4 * REG_RESOLUTION);
    pwdata <= APB_DW'(data);
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    if (!wr && prdata[15:0] !== res_copy) begin
      $error("resolution readback: expected %0d, got %0d", res_copy, prdata[15:0]);
      errors++;
    end
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  // Changes the divisor only once every outstanding result is home and the pipeline has
  // had time to empty, then reads it back.
  task automatic set_resolution(input logic [15:0] r);
    in_valid_i <= 1'b0;
    while (noise_due.size() != 0) @(posedge clk_i);
    repeat (PIPE_DRAIN) @(posedge clk_i);
    apb_access(1'b1, r);
    res_copy = r;
    apb_access(1'b0, '0);
  endtask

  // Receiver: random stalls, one long hold-off partway through, and the check itself.
  initial begin : result_side
    int stall;
    logic signed [15:0] want;
    @(posedge rst_ni);
    forever begin
      stall = $urandom_range(0, 9);
      if (beats_sent % 300 < 60) stall = 0;
      if (!hold_done && beats_sent > 700) begin
        stall = 400;
        hold_done = 1'b1;
      end
      repeat (stall) begin
        out_ready_i <= 1'b0;
        @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      do @(posedge clk_i); while (!out_valid_o);
      if (noise_due.size() == 0) begin
        $error("noise_value beat with nothing expected: %0d", noise_value_o);
        errors++;
      end else begin
        want = noise_due.pop_front();
        noise_checked++;
        if (noise_value_o !== want) begin
          $error("noise_value: expected %0d, got %0d", want, noise_value_o);
          errors++;
        end
      end
    end
  end

  // Directed rows. Integer lattice points always give zero noise, whatever the table holds.
  noise_req_t directed [ROWS] = '{
    '{MODE_LOAD, 8'd0,   8'hFF, 32'sd0, 32'sd0, 1'b0, 16'sd0},
    '{MODE_LOAD, 8'd255, 8'h00, 32'sd0, 32'sd0, 1'b0, 16'sd0},
    '{MODE_LOAD, 8'd1,   8'h07, 32'sd0, 32'sd0, 1'b0, 16'sd0},
    '{MODE_EVAL, 8'd0, 8'd0, 32'sh0000_0000, 32'sh0000_0000, 1'b1, 16'sd0},
    '{MODE_EVAL, 8'd0, 8'd0, 32'sh7FFF_0000, 32'sh8000_0000, 1'b1, 16'sd0},
    '{MODE_EVAL, 8'd0, 8'd0, 32'shFFFF_0000, 32'sh0003_0000, 1'b1, 16'sd0},
    '{MODE_EVAL, 8'd0, 8'd0, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 1'b0, 16'sd0},
    '{MODE_EVAL, 8'd0, 8'd0, 32'sh8000_0000, 32'sh7FFF_FFFF, 1'b0, 16'sd0},
    '{MODE_EVAL, 8'd0, 8'd0, 32'shFFFF_FFFF, 32'shFFFF_FFFF, 1'b0, 16'sd0},
    '{MODE_EVAL, 8'd0, 8'd0, 32'sh0000_8000, 32'sh0000_8000, 1'b0, 16'sd0},
    '{MODE_EVAL, 8'd0, 8'd0, 32'shFFFF_8000, 32'sh0000_0001, 1'b0, 16'sd0},
    '{MODE_EVAL, 8'd0, 8'd0, 32'sh00FF_C000, 32'shFF00_4000, 1'b0, 16'sd0},
    '{MODE_LOAD, 8'd0,   8'h00, 32'sd0, 32'sd0, 1'b0, 16'sd0},
    '{MODE_EVAL, 8'd0, 8'd0, 32'sh0000_4000, 32'sh0000_C000, 1'b0, 16'sd0},
    '{MODE_EVAL, 8'd0, 8'd0, 32'shAAAA_5555, 32'sh5555_AAAA, 1'b0, 16'sd0},
    '{MODE_EVAL, 8'd0, 8'd0, 32'sh0001_0000, 32'shFFFF_0000, 1'b1, 16'sd0}
  };

  initial begin : stimulus
    logic [15:0] settings [6];
    noise_req_t b;
    int per_phase;
    res_copy = RES_RESET;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    apb_access(1'b0, '0);

    // Every slot is written before the first evaluation reads the table.
    b = '0;
    for (int k = 0; k < TABLE_SIZE; k++) begin
      b.mode = MODE_LOAD;
      b.idx = 8'(k);
      b.val = 8'($urandom);
      send_beat(b);
    end
    foreach (directed[k]) send_beat(directed[k]);

    settings[0] = RES_RESET;
    settings[1] = 16'd1;
    settings[2] = 16'd65535;
    settings[3] = 16'd0;
    settings[4] = 16'($urandom_range(1, 65535));
    settings[5] = 16'($urandom_range(16, 1024));
    per_phase = (1600 - TABLE_SIZE - ROWS) / 6;
    foreach (settings[p]) begin
      set_resolution(settings[p]);
      for (int k = 0; k < per_phase; k++) begin
        b = '0;
        b.mode = ($urandom_range(0, 9) == 0) ? MODE_LOAD : MODE_EVAL;
        b.idx = 8'($urandom);
        b.val = 8'($urandom);
        if ($urandom_range(0, 2) == 0) begin
          // Points close to the origin, both signs, so neighbouring cells are hit.
          b.x = 32'(int'($urandom_range(0, 8) << 16) + int'($urandom_range(0, 65535)));
          b.y = 32'(int'($urandom_range(0, 8) << 16) + int'($urandom_range(0, 65535)));
          if ($urandom_range(0, 1)) b.x = -b.x;
          if ($urandom_range(0, 1)) b.y = -b.y;
        end else begin
          b.x = 32'($urandom);
          b.y = 32'($urandom);
        end
        send_beat(b);
      end
    end

    in_valid_i <= 1'b0;
    while (noise_due.size() != 0) @(posedge clk_i);
    repeat (PIPE_DRAIN) @(posedge clk_i);
    $display("Covered %0d beats over six divisor settings, %0d noise samples checked,",
             beats_sent, noise_checked);
    $display("including a long receiver hold-off that backed the pipeline up.");
    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// File: files.f
+incdir+rtl
rtl/pns_pkg.sv
rtl/pns_locate.sv
rtl/pns_lookup.sv
rtl/pns_blend.sv
rtl/perlin_noise_2d_sampler_unit.sv
rtl/pns_checker.sv
bench/testbench.sv
